[src/lats_pkg.sv]
// ----------------------------------------------------------------------------
// lats_pkg
// Shared types and constants for the toroidal Life stepper.
// ----------------------------------------------------------------------------
package lats_pkg;

    localparam int GRID_WIDTH_DEF  = 16;
    localparam int GRID_HEIGHT_DEF = 8;

    localparam int ACTION_W = 2;
    localparam int COL_W    = 4;
    localparam int ROW_W    = 3;
    // wide enough for any row or column index up to the largest grid
    localparam int COORD_W  = 7;
    localparam int COUNT_W  = 4;

    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_STEP  = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef struct packed {
        logic             step;
        logic             write;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             cell_in;
    } lats_ctrl_t;

    typedef struct packed {
        logic rd_bit;
        logic still;
        logic period_two;
    } lats_stat_t;

endpackage

[src/lats_in_if.sv]
// ----------------------------------------------------------------------------
// lats_in_if
// Command channel: action and cell coordinates, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lats_in_if;
    import lats_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic                cell_in;

    modport source (output valid, output action, output col, output row,
                    output cell_in, input ready);
    modport sink   (input valid, input action, input col, input row,
                    input cell_in, output ready);
endinterface

[src/lats_out_if.sv]
// ----------------------------------------------------------------------------
// lats_out_if
// Result channel: cell read value and step flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lats_out_if;
    logic valid;
    logic ready;
    logic cell_out;
    logic still_flag;
    logic period_two_flag;

    modport source (output valid, output cell_out, output still_flag,
                    output period_two_flag, input ready);
    modport sink   (input valid, input cell_out, input still_flag,
                    input period_two_flag, output ready);
endinterface

[src/lats_cell.sv]
// ----------------------------------------------------------------------------
// lats_cell
// One grid cell: current and previous generation bit, Life rule from the
// eight neighbor bits, and per-cell match bits for the step flags.
// ----------------------------------------------------------------------------
module lats_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] nbr,
    input  logic       step,
    input  logic       wr_en,
    input  logic       wr_val,
    output logic       now,
    output logic       match_now,
    output logic       match_prev
);
    import lats_pkg::*;

    logic               now_reg;
    logic               now_next;
    logic               prev_reg;
    logic               prev_next;
    logic [COUNT_W-1:0] cnt;
    logic               life;

    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            cnt = cnt + COUNT_W'(nbr[i]);
        end
    end

    assign life = (cnt == COUNT_W'(BIRTH_COUNT)) ||
                  ((cnt == COUNT_W'(SURVIVE_COUNT)) && now_reg);

    always_comb
    begin
        now_next  = now_reg;
        prev_next = prev_reg;
        if (step)
        begin
            now_next  = life;
            prev_next = now_reg;
        end
        else if (wr_en)
        begin
            now_next = wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg  <= 1'b0;
            prev_reg <= 1'b0;
        end
        else
        begin
            now_reg  <= now_next;
            prev_reg <= prev_next;
        end
    end

    assign now        = now_reg;
    assign match_now  = (life == now_reg);
    assign match_prev = (life == prev_reg);

endmodule

[src/lats_array.sv]
// ----------------------------------------------------------------------------
// lats_array
// Torus of Life cells with wrap-around neighbor wiring, cell select for
// writes and reads, and reduction of the per-cell match bits.
// ----------------------------------------------------------------------------
module lats_array #(
    parameter int GRID_WIDTH  = lats_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lats_pkg::GRID_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lats_pkg::lats_ctrl_t ctrl,
    output lats_pkg::lats_stat_t stat
);
    import lats_pkg::*;

    logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] now_grid;
    logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] sel_grid;
    logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] still_grid;
    logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] ptwo_grid;

    for (genvar r = 0; r < GRID_HEIGHT; r++)
    begin : g_row
        localparam int RP = (r + GRID_HEIGHT - 1) % GRID_HEIGHT;
        localparam int RN = (r + 1) % GRID_HEIGHT;
        logic row_hit;

        assign row_hit = (COORD_W'(ctrl.row) == COORD_W'(r));

        for (genvar c = 0; c < GRID_WIDTH; c++)
        begin : g_col
            localparam int CP = (c + GRID_WIDTH - 1) % GRID_WIDTH;
            localparam int CN = (c + 1) % GRID_WIDTH;
            logic [7:0] nbr;

            assign nbr = {now_grid[RP][CP], now_grid[RP][c], now_grid[RP][CN],
                          now_grid[r][CP],                   now_grid[r][CN],
                          now_grid[RN][CP], now_grid[RN][c], now_grid[RN][CN]};

            // coordinates outside the grid never match any cell
            assign sel_grid[r][c] = row_hit &&
                                    (COORD_W'(ctrl.col) == COORD_W'(c));

            lats_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .nbr        (nbr),
                .step       (ctrl.step),
                .wr_en      (ctrl.write && sel_grid[r][c]),
                .wr_val     (ctrl.cell_in),
                .now        (now_grid[r][c]),
                .match_now  (still_grid[r][c]),
                .match_prev (ptwo_grid[r][c])
            );
        end
    end

    assign stat.rd_bit     = |(now_grid & sel_grid);
    assign stat.still      = &still_grid;
    assign stat.period_two = &ptwo_grid;

endmodule

[src/life_automaton_torus_step_top.sv]
// ----------------------------------------------------------------------------
// life_automaton_torus_step_top
// Conway Life on a wrapping grid with one generation of history; write,
// read and step commands, one registered result per command.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                  | handshake
//  --------+-----+-----------------------------------------+-------------
//  cmd     | in  | action, col, row, cell_in               | valid/ready
//  rsp     | out | cell_out, still_flag, period_two_flag   | valid/ready
//
//  One command per cycle. Its result is registered and shows on rsp the
//  cycle after the transfer. A step updates every cell at once from its
//  neighbor wires; the flags come from an AND over all per-cell match bits.
//  cmd.ready drops only while a result is held and rsp.ready is low.
//  Reset clears every cell at once; no clearing pass.
// ----------------------------------------------------------------------------
module life_automaton_torus_step_top #(
    parameter int GRID_WIDTH  = lats_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lats_pkg::GRID_HEIGHT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lats_in_if.sink   cmd,
    lats_out_if.source rsp
);
    import lats_pkg::*;

    lats_ctrl_t ctrl;
    lats_stat_t stat;

    logic xfer;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic cell_out_reg;
    logic cell_out_next;
    logic still_reg;
    logic still_next;
    logic ptwo_reg;
    logic ptwo_next;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign xfer      = cmd.valid && cmd.ready;

    assign ctrl.step    = xfer && (cmd.action == ACT_STEP);
    assign ctrl.write   = xfer && (cmd.action == ACT_WRITE);
    assign ctrl.row     = cmd.row;
    assign ctrl.col     = cmd.col;
    assign ctrl.cell_in = cmd.cell_in;

    lats_array #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_array (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    always_comb
    begin
        cell_out_next = 1'b0;
        still_next    = 1'b0;
        ptwo_next     = 1'b0;
        case (cmd.action)
            ACT_READ:
            begin
                cell_out_next = stat.rd_bit;
            end
            ACT_STEP:
            begin
                still_next = stat.still;
                ptwo_next  = stat.period_two;
            end
            default:
            begin
                cell_out_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (xfer)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            cell_out_reg <= cell_out_next;
            still_reg    <= still_next;
            ptwo_reg     <= ptwo_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.cell_out        = cell_out_reg;
    assign rsp.still_flag      = still_reg;
    assign rsp.period_two_flag = ptwo_reg;

`ifndef SYNTH
    // every accepted command leaves a result in the output register
    a_xfer_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |=> rsp.valid)
        else $error("accepted command produced no result");

    // a read result never carries step flags
    a_read_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.cell_out) |-> (!rsp.still_flag && !rsp.period_two_flag))
        else $error("read result with step flags set");

    // a still grid stays still and also matches the generation before it
    a_still_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && stat.still) |=> (stat.still && stat.period_two))
        else $error("still grid changed after step");
`endif

endmodule

[verif/life_automaton_torus_step_top_tb.sv]
// ----------------------------------------------------------------------------
// life_automaton_torus_step_top_tb
// Self-checking bench for the toroidal Life stepper. Drives write, read and
// step commands, keeps its own grid and history to predict each response,
// and compares every rsp transfer against it under varying backpressure.
// ----------------------------------------------------------------------------
module life_automaton_torus_step_top_tb;
    import lats_pkg::*;

    localparam int LIFE_W = GRID_WIDTH_DEF;
    localparam int LIFE_H = GRID_HEIGHT_DEF;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 16;
    localparam int MAX_REPORTS    = 10;

    typedef enum int {
        PAT_BLINKER,
        PAT_BLOCK,
        PAT_GLIDER,
        PAT_TOAD,
        PAT_BEEHIVE,
        PAT_SOUP
    } pattern_t;

    logic clk = 1'b0;
    logic rst_n;

    lats_in_if  cmd_if ();
    lats_out_if rsp_if ();

    life_automaton_torus_step_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    // predicted grid state
    logic [LIFE_W-1:0] life_now  [LIFE_H];
    logic [LIFE_W-1:0] life_prev [LIFE_H];
    lats_stat_t        life_expected [$];

    int send_idle_pct;
    int rsp_stall_pct;
    int rsp_hold_left;
    int sent_count;
    int fail_count;
    int idle_cycles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int live_neighbors(int r, int c);
        int n = 0;
        int rr;
        int cc;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                if (dr == 0 && dc == 0)
                    continue;
                rr = (r + LIFE_H + dr) % LIFE_H;
                cc = (c + LIFE_W + dc) % LIFE_W;
                n += int'(life_now[rr][cc]);
            end
        end
        return n;
    endfunction

    function automatic lats_stat_t life_predict(logic [ACTION_W-1:0] act,
                                                logic [COL_W-1:0] col,
                                                logic [ROW_W-1:0] row,
                                                logic cell_val);
        lats_stat_t        res;
        logic [LIFE_W-1:0] next_gen [LIFE_H];
        logic              on_grid;
        logic              same_now;
        logic              same_prev;
        int                n;
        res = '0;
        on_grid = (int'(col) < LIFE_W) && (int'(row) < LIFE_H);
        case (act)
            ACT_WRITE:
            begin
                if (on_grid)
                    life_now[row][col] = cell_val;
            end
            ACT_STEP:
            begin
                for (int r = 0; r < LIFE_H; r++)
                begin
                    for (int c = 0; c < LIFE_W; c++)
                    begin
                        n = live_neighbors(r, c);
                        next_gen[r][c] = (n == BIRTH_COUNT) ||
                                         (n == SURVIVE_COUNT && life_now[r][c]);
                    end
                end
                same_now  = 1'b1;
                same_prev = 1'b1;
                for (int r = 0; r < LIFE_H; r++)
                begin
                    if (next_gen[r] != life_now[r])
                        same_now = 1'b0;
                    if (next_gen[r] != life_prev[r])
                        same_prev = 1'b0;
                end
                res.still      = same_now;
                res.period_two = same_prev;
                for (int r = 0; r < LIFE_H; r++)
                begin
                    life_prev[r] = life_now[r];
                    life_now[r]  = next_gen[r];
                end
            end
            ACT_READ:
            begin
                if (on_grid)
                    res.rd_bit = life_now[row][col];
            end
            default: ;
        endcase
        return res;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_cmd(logic [ACTION_W-1:0] act, logic [COL_W-1:0] col,
                            logic [ROW_W-1:0] row, logic cell_val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.action  <= act;
        cmd_if.col     <= col;
        cmd_if.row     <= row;
        cmd_if.cell_in <= cell_val;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        life_expected.push_back(life_predict(act, col, row, cell_val));
        sent_count++;
        @(negedge clk);
    endtask

    task automatic write_cell(int r, int c, logic val);
        send_cmd(ACT_WRITE, COL_W'(c), ROW_W'(r), val);
    endtask

    task automatic read_cell(int r, int c);
        send_cmd(ACT_READ, COL_W'(c), ROW_W'(r), 1'($urandom_range(1)));
    endtask

    task automatic step_grid();
        send_cmd(ACT_STEP, COL_W'($urandom_range(15)), ROW_W'($urandom_range(7)),
                 1'($urandom_range(1)));
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (life_expected.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic clear_live_cells();
        for (int r = 0; r < LIFE_H; r++)
        begin
            for (int c = 0; c < LIFE_W; c++)
            begin
                if (life_now[r][c])
                    write_cell(r, c, 1'b0);
            end
        end
    endtask

    task automatic place_pattern(pattern_t kind, int r0, int c0);
        int dr [$];
        int dc [$];
        int n;
        case (kind)
            PAT_BLINKER: begin dr = '{0, 0, 0}; dc = '{0, 1, 2}; end
            PAT_BLOCK:   begin dr = '{0, 0, 1, 1}; dc = '{0, 1, 0, 1}; end
            PAT_GLIDER:  begin dr = '{0, 1, 2, 2, 2}; dc = '{1, 2, 0, 1, 2}; end
            PAT_TOAD:    begin dr = '{0, 0, 0, 1, 1, 1}; dc = '{1, 2, 3, 0, 1, 2}; end
            PAT_BEEHIVE: begin dr = '{0, 0, 1, 1, 2, 2}; dc = '{1, 2, 0, 3, 1, 2}; end
            default:
            begin
                n = $urandom_range(6, 24);
                repeat (n)
                begin
                    dr.push_back($urandom_range(3));
                    dc.push_back($urandom_range(5));
                end
            end
        endcase
        // soup cells are mostly live, sometimes a kill
        foreach (dr[i])
            write_cell((r0 + dr[i]) % LIFE_H, (c0 + dc[i]) % LIFE_W,
                       (kind != PAT_SOUP) || ($urandom_range(3) != 0));
    endtask

    task automatic run_life_episode();
        int steps;
        int reads;
        if ($urandom_range(1) == 1)
            clear_live_cells();
        place_pattern(pattern_t'($urandom_range(5)), $urandom_range(LIFE_H - 1),
                      $urandom_range(LIFE_W - 1));
        if ($urandom_range(3) == 0)
            send_cmd(ACTION_W'($urandom_range(3)), COL_W'($urandom_range(15)),
                     ROW_W'($urandom_range(7)), 1'($urandom_range(1)));
        steps = $urandom_range(1, 8);
        repeat (steps)
        begin
            step_grid();
            reads = $urandom_range(2);
            repeat (reads)
                read_cell($urandom_range(LIFE_H - 1), $urandom_range(LIFE_W - 1));
        end
    endtask

    task automatic test_reset_state();
        read_cell(0, 0);
        read_cell(LIFE_H - 1, LIFE_W - 1);
        step_grid();
    endtask

    task automatic test_corner_cells();
        write_cell(0, 0, 1'b1);
        write_cell(LIFE_H - 1, LIFE_W - 1, 1'b1);
        read_cell(0, 0);
        read_cell(LIFE_H - 1, LIFE_W - 1);
        write_cell(0, 0, 1'b0);
        write_cell(LIFE_H - 1, LIFE_W - 1, 1'b0);
        read_cell(LIFE_H - 1, LIFE_W - 1);
    endtask

    task automatic test_unused_action();
        send_cmd(ACT_UNUSED, '0, '0, 1'b1);
        read_cell(0, 0);
    endtask

    // blinker across the column seam: flips to vertical across the row seam
    task automatic test_wrap_blinker();
        place_pattern(PAT_BLINKER, 0, LIFE_W - 1);
        repeat (3)
            step_grid();
    endtask

    // block on all four corners; history still holds the blinker
    task automatic test_wrap_block();
        clear_live_cells();
        place_pattern(PAT_BLOCK, LIFE_H - 1, LIFE_W - 1);
        step_grid();
    endtask

    task automatic test_random_mix(int idle_pct, int stall_pct, int n_items);
        int stop;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        stop = sent_count + n_items;
        while (sent_count < stop)
            run_life_episode();
        drain_results();
    endtask

    task automatic test_rsp_hold_off();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        clear_live_cells();
        rsp_hold_left = HOLD_CYCLES;
        place_pattern(PAT_GLIDER, 2, 5);
        repeat (12)
        begin
            step_grid();
            read_cell($urandom_range(LIFE_H - 1), $urandom_range(LIFE_W - 1));
        end
        drain_results();
    endtask

    task automatic test_sender_pause();
        send_idle_pct = 0;
        rsp_stall_pct = 50;
        clear_live_cells();
        place_pattern(PAT_TOAD, 3, 9);
        step_grid();
        drain_results();
        step_grid();
        drain_results();
        read_cell(3, 10);
        drain_results();
    endtask

    always @(negedge clk)
    begin
        if (rsp_hold_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            rsp_hold_left--;
        end
        else
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        lats_stat_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (life_expected.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("rsp transfer with nothing pending: cell=%b still=%b p2=%b",
                             rsp_if.cell_out, rsp_if.still_flag, rsp_if.period_two_flag);
            end
            else
            begin
                want = life_expected.pop_front();
                if ({rsp_if.cell_out, rsp_if.still_flag, rsp_if.period_two_flag} !== want)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"mismatch: want cell=%b still=%b p2=%b,",
                                  " got cell=%b still=%b p2=%b"},
                                 want.rd_bit, want.still, want.period_two,
                                 rsp_if.cell_out, rsp_if.still_flag,
                                 rsp_if.period_two_flag);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** life_automaton_torus_step_top: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.action  = ACT_WRITE;
        cmd_if.col     = '0;
        cmd_if.row     = '0;
        cmd_if.cell_in = 1'b0;
        rsp_if.ready   = 1'b0;
        send_idle_pct  = 0;
        rsp_stall_pct  = 0;
        rsp_hold_left  = 0;
        sent_count     = 0;
        fail_count     = 0;
        idle_cycles    = 0;
        for (int r = 0; r < LIFE_H; r++)
        begin
            life_now[r]  = '0;
            life_prev[r] = '0;
        end
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_corner_cells();
        test_unused_action();
        test_wrap_blinker();
        test_wrap_block();
        drain_results();

        test_random_mix(0, 0, 300);
        test_random_mix(83, 0, 300);
        test_random_mix(0, 83, 300);
        test_random_mix(27, 27, 300);
        test_rsp_hold_off();
        test_sender_pause();

        while (life_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && life_expected.size() == 0)
            $display("** life_automaton_torus_step_top: PASSED **");
        else
            $display("** life_automaton_torus_step_top: FAILED **");
        $finish;
    end

endmodule
